>>> src/cbd_pkg.sv
package cbd_pkg;

  localparam int unsigned BlockBytes = 7;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned BlockW     = BlockBytes * ByteW;
  localparam int unsigned ApbDataW   = 64;
  localparam int unsigned ApbAddrW   = 4;

  localparam logic [BlockW-1:0] KeyReset = 56'h1A2B3C4D5E6F00;

  typedef enum logic {
    RegInitialKey = 1'b0,
    RegNone       = 1'b1
  } cbd_reg_e;

  typedef struct packed {
    logic [BlockW-1:0] block;
    logic              reload;
    logic              odd;
  } cbd_item_t;

  function automatic logic [ByteW-1:0] swap_nib(input logic [ByteW-1:0] b);
    return {b[ByteW/2-1:0], b[ByteW-1:ByteW/2]};
  endfunction

endpackage

>>> src/cbd_in_if.sv
interface cbd_in_if;
  import cbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BlockW-1:0] cipher_block;
  logic              frame_start;

  modport source (output valid, output cipher_block, output frame_start, input ready);
  modport sink (input valid, input cipher_block, input frame_start, output ready);
endinterface

>>> src/cbd_out_if.sv
interface cbd_out_if;
  import cbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BlockW-1:0] plain_block;

  modport source (output valid, output plain_block, input ready);
  modport sink (input valid, input plain_block, output ready);
endinterface

>>> src/cbd_front.sv
module cbd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  cbd_in_if.sink             blk_in_i,
  input  logic               q_ready_i,
  output logic               q_valid_o,
  output cbd_pkg::cbd_item_t q_item_o
);
  import cbd_pkg::*;

  logic odd_q, odd_d;
  logic accept;
  logic odd_eff;

  assign blk_in_i.ready = q_ready_i;
  assign q_valid_o      = blk_in_i.valid;
  assign accept         = blk_in_i.valid && q_ready_i;

  // A frame start restarts the block parity at even.
  assign odd_eff = blk_in_i.frame_start ? 1'b0 : odd_q;

  always_comb begin
    q_item_o.block  = blk_in_i.cipher_block;
    q_item_o.reload = blk_in_i.frame_start;
    q_item_o.odd    = odd_eff;
    odd_d           = accept ? !odd_eff : odd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odd_q <= 1'b0;
    end else begin
      odd_q <= odd_d;
    end
  end
endmodule

>>> src/cbd_fifo.sv
module cbd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cbd_pkg::cbd_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output cbd_pkg::cbd_item_t pop_item_o
);
  import cbd_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastPtr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt = CntW'(Depth);

  cbd_item_t        mem_q [Depth];
  logic [AddrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end
endmodule

>>> src/cbd_back.sv
module cbd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [cbd_pkg::BlockW-1:0] init_key_i,
  input  logic                       q_empty_i,
  input  cbd_pkg::cbd_item_t         q_item_i,
  output logic                       q_pop_o,
  cbd_out_if.source                  blk_out_o
);
  import cbd_pkg::*;

  logic [BlockW-1:0] key_q, key_d;
  logic [BlockW-1:0] key_eff;
  logic [BlockW-1:0] x_word;
  logic [BlockW-1:0] plain_q, plain_d;
  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  x [BlockBytes];
  logic [ByteW-1:0]  c [BlockBytes];
  logic [ByteW-1:0]  b;
  logic              sw;

  assign q_pop_o = !q_empty_i && (!out_valid_q || blk_out_o.ready);
  assign key_eff = q_item_i.reload ? init_key_i : key_q;

  always_comb begin
    for (int k = 0; k < BlockBytes; k++) begin
      b    = q_item_i.block[BlockW-1-ByteW*k -: ByteW];
      sw   = q_item_i.odd ? ((k % 2) == 0) : ((k % 2) == 1);
      x[k] = sw ? swap_nib(b) : b;
    end
    c[0] = q_item_i.odd ? x[0] : (x[BlockBytes-1] ^ x[0]);
    for (int k = 1; k < BlockBytes; k++) begin
      c[k] = x[k-1] ^ x[k];
    end
    if (!q_item_i.odd) begin
      c[1] = x[1];
    end
    for (int k = 0; k < BlockBytes; k++) begin
      plain_d[BlockW-1-ByteW*k -: ByteW] = c[k] - key_eff[BlockW-1-ByteW*k -: ByteW];
      x_word[BlockW-1-ByteW*k -: ByteW]  = x[k];
    end
  end

  always_comb begin
    key_d       = key_q;
    out_valid_d = out_valid_q;
    if (q_pop_o) begin
      key_d       = q_item_i.odd ? x_word : key_eff;
      out_valid_d = 1'b1;
    end else if (blk_out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= KeyReset;
      out_valid_q <= 1'b0;
    end else begin
      key_q       <= key_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      plain_q <= plain_d;
    end
  end

  assign blk_out_o.valid       = out_valid_q;
  assign blk_out_o.plain_block = plain_q;
endmodule

>>> src/chained_block_descrambler_core.sv
// Descrambles one 7-byte block per transaction and sustains one transaction per clock cycle
// while the output is not stalled. An accepted block is written into a short queue, and its
// plain block is loaded into the output register when the back end pops it; the queue holds
// QueueDepth blocks and the output register one more, after which the input deasserts ready.
// The running key update from an odd block is applied by the back end in the same cycle it
// produces that block's result, which keeps the rate at one block per cycle while the output
// is not stalled. The initial key is a 56-bit register at APB byte address 0, read and
// written through the 64-bit data bus; it takes effect at the next frame start.
module chained_block_descrambler_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cbd_in_if.sink                       blk_in_i,
  cbd_out_if.source                    blk_out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cbd_pkg::ApbAddrW-1:0] paddr,
  input  logic [cbd_pkg::ApbDataW-1:0] pwdata,
  output logic [cbd_pkg::ApbDataW-1:0] prdata,
  output logic                         pready
);
  import cbd_pkg::*;

  logic [BlockW-1:0] init_key_q, init_key_d;
  cbd_reg_e          reg_sel;
  logic              wr_en;
  logic              fe_valid, q_full, q_empty, q_pop;
  cbd_item_t         fe_item, q_item;

  assign pready  = 1'b1;
  assign reg_sel = cbd_reg_e'(paddr[ApbAddrW-1]);
  assign wr_en   = psel && penable && pwrite && (reg_sel == RegInitialKey);

  always_comb begin
    unique case (reg_sel)
      RegInitialKey: prdata = ApbDataW'(init_key_q);
      default:       prdata = '0;
    endcase
  end

  assign init_key_d = wr_en ? pwdata[BlockW-1:0] : init_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_key_q <= KeyReset;
    end else begin
      init_key_q <= init_key_d;
    end
  end

  cbd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .blk_in_i  (blk_in_i),
    .q_ready_i (!q_full),
    .q_valid_o (fe_valid),
    .q_item_o  (fe_item)
  );

  cbd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fe_valid),
    .push_item_i (fe_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_item_o  (q_item)
  );

  cbd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .init_key_i (init_key_q),
    .q_empty_i  (q_empty),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .blk_out_o  (blk_out_o)
  );
endmodule

>>> src/cbd_checker.sv
module cbd_sva #(
  parameter int unsigned Depth = 2
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [cbd_pkg::BlockW-1:0] plain_block_i,
  input logic                       pready
);
  import cbd_pkg::*;

  localparam int unsigned CntW = $clog2(Depth + 2);
  localparam logic [CntW-1:0] MaxCnt = CntW'(Depth + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (out_acc && !in_acc) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(plain_block_i))
    else $error("Output transaction dropped or changed while stalled.");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !out_valid_i)
    else $error("Output transaction without a pending input transaction.");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == MaxCnt) |-> !in_ready_i)
    else $error("Input accepted with all storage occupied.");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("Configuration port inserted a wait state.");
endmodule

bind chained_block_descrambler_core cbd_sva #(
  .Depth (QueueDepth)
) u_cbd_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (blk_in_i.valid),
  .in_ready_i    (blk_in_i.ready),
  .out_valid_i   (blk_out_o.valid),
  .out_ready_i   (blk_out_o.ready),
  .plain_block_i (blk_out_o.plain_block),
  .pready        (pready)
);

>>> tb/cbd_checker.sv
`timescale 1ns / 1ps

module cbd_checker
  import cbd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  cbd_in_if                   blk_in_i,
  cbd_out_if                  blk_out_i,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  input  logic [ApbDataW-1:0] prdata,
  input  logic                pready,
  output int                  mismatches_o,
  output int                  pending_o,
  output int                  checked_o
);

  localparam int RegStride = 8;
  localparam logic [ApbAddrW-1:0] KeyAddr = ApbAddrW'(int'(RegInitialKey) * RegStride);

  logic [BlockW-1:0] init_key;
  logic [BlockW-1:0] run_key;
  logic              odd_q;
  logic [BlockW-1:0] plain_q[$];

  function automatic logic [BlockW-1:0] descramble(input logic [BlockW-1:0] cipher,
                                                   input logic            first);
    logic [ByteW-1:0]  x[BlockBytes];
    logic [ByteW-1:0]  chain;
    logic [BlockW-1:0] swapped;
    logic [BlockW-1:0] plain;
    if (first) begin
      run_key = init_key;
      odd_q   = 1'b0;
    end
    for (int k = 0; k < BlockBytes; k++) begin
      x[k] = cipher[BlockW-1-ByteW*k -: ByteW];
      if ((k % 2 == 1) != odd_q) begin
        x[k] = {x[k][ByteW/2-1:0], x[k][ByteW-1:ByteW/2]};
      end
      swapped[BlockW-1-ByteW*k -: ByteW] = x[k];
    end
    for (int k = 0; k < BlockBytes; k++) begin
      if (k == 0) begin
        chain = odd_q ? x[0] : (x[BlockBytes-1] ^ x[0]);
      end else if (k == 1 && !odd_q) begin
        chain = x[1];
      end else begin
        chain = x[k-1] ^ x[k];
      end
      plain[BlockW-1-ByteW*k -: ByteW] = chain - run_key[BlockW-1-ByteW*k -: ByteW];
    end
    if (odd_q) begin
      run_key = swapped;
    end
    odd_q = !odd_q;
    return plain;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [BlockW-1:0] want;
    if (!rst_ni) begin
      init_key = KeyReset;
      run_key  = KeyReset;
      odd_q    = 1'b0;
      plain_q.delete();
      mismatches_o = 0;
      checked_o    = 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && !pwrite && pready && paddr == KeyAddr) begin
        if (prdata[BlockW-1:0] !== init_key) begin
          $display("%0t: key readback mismatch, expected %h, got %h",
                   $time, init_key, prdata[BlockW-1:0]);
          mismatches_o++;
        end
      end
      if (psel && penable && pwrite && pready && paddr == KeyAddr) begin
        init_key = pwdata[BlockW-1:0];
      end
      if (blk_in_i.valid && blk_in_i.ready) begin
        plain_q.push_back(descramble(blk_in_i.cipher_block, blk_in_i.frame_start));
      end
      if (blk_out_i.valid && blk_out_i.ready) begin
        checked_o++;
        if (plain_q.size() == 0) begin
          $display("%0t: unexpected plain block, expected none, got %h",
                   $time, blk_out_i.plain_block);
          mismatches_o++;
        end else begin
          want = plain_q.pop_front();
          if (blk_out_i.plain_block !== want) begin
            $display("%0t: plain block mismatch, expected %h, got %h",
                     $time, want, blk_out_i.plain_block);
            mismatches_o++;
          end
        end
      end
      pending_o <= plain_q.size();
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import cbd_pkg::*;

  localparam int RegStride    = 8;
  localparam int PhaseItems   = 306;
  localparam int HoldCycles   = 60;
  localparam int DrainLimit   = 5000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int mismatches;
  int pending;
  int checked;
  int blocks_sent;
  int frames_sent;
  int key_settings;
  bit gaps_on;
  bit stalls_on;
  bit hold_req;

  cbd_in_if  in_if ();
  cbd_out_if out_if ();

  chained_block_descrambler_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .blk_in_i (in_if),
    .blk_out_o(out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  cbd_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_in_i    (in_if),
    .blk_out_i   (out_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #2_400_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [ApbAddrW-1:0] reg_addr(input cbd_reg_e r);
    return ApbAddrW'(int'(r) * RegStride);
  endfunction

  function automatic logic [BlockW-1:0] rand_block();
    logic [BlockW-1:0] b;
    b = BlockW'({$urandom, $urandom});
    case ($urandom_range(15))
      0: b = '0;
      1: b = '1;
      default: ;
    endcase
    return b;
  endfunction

  task automatic apb_write(input cbd_reg_e r, input logic [ApbDataW-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= reg_addr(r);
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (r == RegInitialKey) key_settings++;
  endtask

  task automatic apb_read(input cbd_reg_e r);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_addr(r);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_block(input logic [BlockW-1:0] blk, input logic fs);
    if (gaps_on) begin
      while ($urandom_range(99) < 16) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_if.valid        <= 1'b1;
    in_if.cipher_block <= blk;
    in_if.frame_start  <= fs;
    do @(posedge clk_i); while (!in_if.ready);
    blocks_sent++;
    if (fs) frames_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_phase(input int n);
    int  sent;
    int  flen;
    logic fs;
    sent = 0;
    while (sent < n) begin
      flen = $urandom_range(1, 12);
      for (int j = 0; j < flen && sent < n; j++) begin
        fs = (j == 0);
        if ($urandom_range(99) < 5) fs = !fs;
        send_block(rand_block(), fs);
        sent++;
      end
    end
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_if.ready <= !(stalls_on && $urandom_range(99) < 16);
    end
  end

  initial begin
    int waited;
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.cipher_block <= '0;
    in_if.frame_start  <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    hold_req  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_read(RegInitialKey);
    send_block(56'h00000000000000, 1'b0);
    send_block(56'hFFFFFFFFFFFFFF, 1'b0);
    send_block(56'hF0F0F0F0F0F0F0, 1'b0);
    send_block(56'h0F0F0F0F0F0F0F, 1'b0);
    send_block(56'h00000000000000, 1'b1);
    send_block(56'hFFFFFFFFFFFFFF, 1'b0);
    send_block(56'h123456789ABCDE, 1'b0);
    send_block(56'hAAAAAAAAAAAAAA, 1'b1);
    send_block(56'h55555555555555, 1'b1);
    send_block(56'h0123456789ABCD, 1'b0);
    send_block(56'hFEDCBA98765432, 1'b1);
    drain();

    apb_write(RegNone, '1);
    apb_read(RegInitialKey);
    apb_write(RegInitialKey, {8'hFF, 56'h00000000000000});
    apb_read(RegInitialKey);
    send_block(56'h13579BDF02468A, 1'b0);
    send_block(56'hFFFFFFFFFFFFFF, 1'b0);
    send_block(56'h00000000000000, 1'b1);
    send_block(56'hFFFFFFFFFFFFFF, 1'b0);
    send_block(56'h80402010080402, 1'b0);
    drain();

    apb_write(RegInitialKey, {8'h00, 56'hFFFFFFFFFFFFFF});
    apb_read(RegInitialKey);
    send_block(56'hFFFFFFFFFFFFFF, 1'b1);
    send_block(56'h00000000000000, 1'b0);
    send_block(56'h7F7F7F7F7F7F7F, 1'b0);
    send_block(56'h01010101010101, 1'b0);
    drain();

    for (int p = 0; p < 5; p++) begin
      gaps_on   = (p != 0);
      stalls_on = (p != 0);
      apb_write(RegInitialKey, {$urandom, $urandom});
      if ($urandom_range(1)) apb_write(RegNone, {$urandom, $urandom});
      apb_read(RegInitialKey);
      if (p == 2) hold_req = 1'b1;
      random_phase(PhaseItems);
      drain();
    end

    waited = 0;
    while (pending != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (pending != 0) $display("%0t: %0d expected plain blocks never arrived", $time, pending);

    $display("Sent %0d blocks in %0d frame starts over %0d key settings; %0d results checked.",
             blocks_sent, frames_sent, key_settings, checked);
    $display("Traffic ran back to back, with random gaps and stalls, and through a long hold.");
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
